// File: rtl/rpcs_pkg.sv
// shared types, constants and helpers for the rotated pixel colour stream
package rpcs_pkg;

    localparam int MAX_DIM = 4096;
    localparam int DIM_W   = $clog2(MAX_DIM) + 1;
    localparam int CNT_W   = $clog2(MAX_DIM);

    localparam int POS_W   = 32;
    localparam int TRIG_W  = 16;
    localparam int CH_W    = 8;
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = 32;

    // bt.601 luma weights scaled by 2^16
    localparam int LUMA_W       = 25;
    localparam int LUMA_K_RED   = 19595;
    localparam int LUMA_K_GREEN = 38470;
    localparam int LUMA_K_BLUE  = 7471;
    localparam int LUMA_ROUND   = 32768;
    localparam int LUMA_SHIFT   = 16;

    typedef enum logic [2:0] {
        MODE_PASS  = 3'd0,
        MODE_BLUE  = 3'd1,
        MODE_RED   = 3'd2,
        MODE_GREEN = 3'd3,
        MODE_GREY  = 3'd4
    } color_mode_t;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_COLOR_MODE   = 3'd0,
        CFG_MIRROR_FLAGS = 3'd1,
        CFG_IMAGE_WIDTH  = 3'd2,
        CFG_IMAGE_HEIGHT = 3'd3,
        CFG_ORIGIN_X     = 3'd4,
        CFG_ORIGIN_Y     = 3'd5,
        CFG_ROT_COS      = 3'd6,
        CFG_ROT_SIN      = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } pixel_t;

    // q1.14 to q16.16 step, sign extended
    function automatic logic [POS_W-1:0] q14_to_step(input logic [TRIG_W-1:0] v);
        q14_to_step = {{(POS_W-TRIG_W-2){v[TRIG_W-1]}}, v, 2'b00};
    endfunction

    // zero counts as one, oversize clamps to the maximum
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        if (d == '0) begin
            eff_dim = DIM_W'(1);
        end else if (d > DIM_W'(MAX_DIM)) begin
            eff_dim = DIM_W'(MAX_DIM);
        end else begin
            eff_dim = d;
        end
    endfunction

endpackage

// File: rtl/rpcs_color.sv
// colour mode mapping and colour change detection
module rpcs_color
    import rpcs_pkg::*;
(
    input  color_mode_t mode,
    input  pixel_t      pix,
    input  pixel_t      last_pix,
    output pixel_t      color,
    output logic        differ
);

    logic [LUMA_W-1:0] luma_sum;
    logic [CH_W-1:0]   luma;
    logic              all_differ;

    assign luma_sum = LUMA_W'(LUMA_K_RED)   * LUMA_W'(pix.red)
                    + LUMA_W'(LUMA_K_GREEN) * LUMA_W'(pix.green)
                    + LUMA_W'(LUMA_K_BLUE)  * LUMA_W'(pix.blue)
                    + LUMA_W'(LUMA_ROUND);
    assign luma = luma_sum[LUMA_SHIFT +: CH_W];

    assign all_differ = (pix != last_pix);

    always_comb begin
        case (mode)
            MODE_GREY: begin
                color  = '{blue: luma, green: luma, red: luma};
                differ = all_differ;
            end
            MODE_GREEN: begin
                color  = '{blue: ~pix.green, green: '1, red: ~pix.green};
                differ = all_differ;
            end
            MODE_RED: begin
                color  = '{blue: ~pix.red, green: ~pix.red, red: '1};
                differ = (pix.red != last_pix.red);
            end
            MODE_BLUE: begin
                color  = '{blue: '1, green: ~pix.blue, red: ~pix.blue};
                differ = (pix.blue != last_pix.blue);
            end
            default: begin
                color  = pix;
                differ = all_differ;
            end
        endcase
    end

endmodule

// File: rtl/rotated_pixel_color_stream_top.sv
// top level: raster scan walker, colour mapping and stream handshake
// an accepted pixel beat moves from the input register to the output register once that is empty or being drained
// throughput: one pixel per cycle while m_tready does not stall the output, input register then output register
// s_tready stays high while the output register is empty or being drained
// reset clears counters, stored pixel and valids; config returns to defaults
module rotated_pixel_color_stream_top
    import rpcs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CFG_A_W-1:0] cfg_addr,
    input  logic [CFG_D_W-1:0] cfg_wr_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [23:0]        s_tdata,   // in_red, in_green, in_blue
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [111:0]       m_tdata,   // pos_x, pos_y, out_red, out_green, out_blue,
                                          // src_col, src_row
    output logic               m_tuser,   // color_set
    output logic               m_tlast    // frame_end
);

    color_mode_t       color_mode_reg;
    logic [1:0]        mirror_flags_reg;
    logic [DIM_W-1:0]  image_width_reg, image_height_reg;
    logic [POS_W-1:0]  origin_x_reg, origin_y_reg;
    logic [TRIG_W-1:0] rot_cos_reg, rot_sin_reg;

    logic              in_vld_reg;
    pixel_t            in_pix_reg;

    logic [CNT_W-1:0]  col_count_reg, row_count_reg;
    logic [CNT_W-1:0]  col_count_next, row_count_next;
    logic [POS_W-1:0]  row_start_x_reg, row_start_y_reg, point_x_reg, point_y_reg;
    logic [POS_W-1:0]  row_start_x_next, row_start_y_next, point_x_next, point_y_next;
    pixel_t            last_pixel_reg, last_pixel_next;

    logic              out_vld_reg;
    logic [POS_W-1:0]  out_pos_x_reg, out_pos_y_reg;
    pixel_t            out_color_reg;
    logic [CNT_W-1:0]  out_src_col_reg, out_src_row_reg;
    logic              out_set_reg, out_end_reg;

    logic              adv, fire;
    logic              frame_start;
    logic [DIM_W-1:0]  w_eff, h_eff;
    logic [DIM_W-1:0]  col_inc, row_inc, col_mir, row_mir;
    logic              col_wrap, row_wrap;
    logic [POS_W-1:0]  cur_px, cur_py, cur_rsx, cur_rsy;
    logic [POS_W-1:0]  step_cos, step_sin;
    pixel_t            last_eff, mapped;
    logic              differ;
    logic [CNT_W-1:0]  src_col, src_row;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_mode_reg   <= MODE_PASS;
            mirror_flags_reg <= '0;
            image_width_reg  <= DIM_W'(1);
            image_height_reg <= DIM_W'(1);
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            rot_cos_reg      <= TRIG_W'(16384);
            rot_sin_reg      <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_addr))
                CFG_COLOR_MODE:   color_mode_reg   <= color_mode_t'(cfg_wr_data[2:0]);
                CFG_MIRROR_FLAGS: mirror_flags_reg <= cfg_wr_data[1:0];
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_wr_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_wr_data[DIM_W-1:0];
                CFG_ORIGIN_X:     origin_x_reg     <= cfg_wr_data;
                CFG_ORIGIN_Y:     origin_y_reg     <= cfg_wr_data;
                CFG_ROT_COS:      rot_cos_reg      <= cfg_wr_data[TRIG_W-1:0];
                CFG_ROT_SIN:      rot_sin_reg      <= cfg_wr_data[TRIG_W-1:0];
                default: ;
            endcase
        end
    end

    assign adv      = !out_vld_reg || m_tready;
    assign fire     = adv && in_vld_reg;
    assign s_tready = !in_vld_reg || adv;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_pix_reg <= pixel_t'({s_tdata[23:16], s_tdata[15:8], s_tdata[7:0]});
        end
    end

    // scan position
    assign frame_start = (col_count_reg == '0) && (row_count_reg == '0);
    assign cur_px   = frame_start ? origin_x_reg : point_x_reg;
    assign cur_py   = frame_start ? origin_y_reg : point_y_reg;
    assign cur_rsx  = frame_start ? origin_x_reg : row_start_x_reg;
    assign cur_rsy  = frame_start ? origin_y_reg : row_start_y_reg;
    assign last_eff = frame_start ? pixel_t'('0) : last_pixel_reg;

    assign step_cos = q14_to_step(rot_cos_reg);
    assign step_sin = q14_to_step(rot_sin_reg);

    assign w_eff    = eff_dim(image_width_reg);
    assign h_eff    = eff_dim(image_height_reg);
    assign col_inc  = {1'b0, col_count_reg} + DIM_W'(1);
    assign row_inc  = {1'b0, row_count_reg} + DIM_W'(1);
    assign col_wrap = (col_inc >= w_eff);
    assign row_wrap = col_wrap && (row_inc >= h_eff);

    // mirrored address wraps modulo the counter width
    assign col_mir  = w_eff - DIM_W'(1) - {1'b0, col_count_reg};
    assign row_mir  = h_eff - DIM_W'(1) - {1'b0, row_count_reg};
    assign src_col  = mirror_flags_reg[0] ? col_mir[CNT_W-1:0] : col_count_reg;
    assign src_row  = mirror_flags_reg[1] ? row_mir[CNT_W-1:0] : row_count_reg;

    rpcs_color u_color (
        .mode     (color_mode_reg),
        .pix      (in_pix_reg),
        .last_pix (last_eff),
        .color    (mapped),
        .differ   (differ)
    );

    always_comb begin
        last_pixel_next  = differ ? in_pix_reg : last_eff;
        row_start_x_next = cur_rsx;
        row_start_y_next = cur_rsy;
        point_x_next     = cur_px + step_cos;
        point_y_next     = cur_py + step_sin;
        col_count_next   = col_inc[CNT_W-1:0];
        row_count_next   = row_count_reg;
        if (col_wrap) begin
            col_count_next   = '0;
            row_start_x_next = cur_rsx - step_sin;
            row_start_y_next = cur_rsy + step_cos;
            point_x_next     = row_start_x_next;
            point_y_next     = row_start_y_next;
            row_count_next   = row_wrap ? '0 : row_inc[CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg   <= '0;
            row_count_reg   <= '0;
            last_pixel_reg  <= '0;
            row_start_x_reg <= '0;
            row_start_y_reg <= '0;
            point_x_reg     <= '0;
            point_y_reg     <= '0;
        end else if (fire) begin
            col_count_reg   <= col_count_next;
            row_count_reg   <= row_count_next;
            last_pixel_reg  <= last_pixel_next;
            row_start_x_reg <= row_start_x_next;
            row_start_y_reg <= row_start_y_next;
            point_x_reg     <= point_x_next;
            point_y_reg     <= point_y_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= in_vld_reg;
        end
        if (fire) begin
            out_pos_x_reg   <= cur_px;
            out_pos_y_reg   <= cur_py;
            out_color_reg   <= mapped;
            out_set_reg     <= differ;
            out_src_col_reg <= src_col;
            out_src_row_reg <= src_row;
            out_end_reg     <= row_wrap;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_src_row_reg, out_src_col_reg, out_color_reg.blue,
                       out_color_reg.green, out_color_reg.red, out_pos_y_reg, out_pos_x_reg};
    assign m_tuser  = out_set_reg;
    assign m_tlast  = out_end_reg;

`ifndef ASSERT_OFF
    // an empty output register must never hold off the input side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_vld_reg |-> s_tready)
        else $error("s_tready low with empty output register");

    // the last pixel of a frame returns the scan to its start
    a_frame_end_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && row_wrap) |=> (col_count_reg == '0 && row_count_reg == '0))
        else $error("counters not cleared after frame end");

    // the first pixel of a frame is plotted at the origin
    a_origin_at_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && frame_start) |=> (out_pos_x_reg == $past(origin_x_reg)
                                   && out_pos_y_reg == $past(origin_y_reg)))
        else $error("frame start not plotted at origin");
`endif

endmodule

// File: tb/tb_top.sv
// testbench for the rotated pixel colour stream: predicts every plot beat and checks the stream
`timescale 1ns / 100ps

module tb_top;
    import rpcs_pkg::*;

    localparam int STUCK_LIMIT = 3000;
    localparam int RANDOM_PIXELS = 1250;
    localparam int unsigned K_RED = 19595;
    localparam int unsigned K_GREEN = 38470;
    localparam int unsigned K_BLUE = 7471;
    localparam int unsigned K_ROUND = 32768;

    typedef struct {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        color_set;
        logic [11:0] src_col;
        logic [11:0] src_row;
        logic        frame_end;
    } plot_beat_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [CFG_A_W-1:0] cfg_addr = CFG_COLOR_MODE;
    logic [CFG_D_W-1:0] cfg_wr_data = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [23:0]        s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [111:0]       m_tdata;
    logic               m_tuser;
    logic               m_tlast;

    // register copies, at their reset values
    logic [2:0]  sh_mode = 3'd0;
    logic [1:0]  sh_mirror = 2'd0;
    logic [12:0] sh_width = 13'd1;
    logic [12:0] sh_height = 13'd1;
    logic [31:0] sh_org_x = '0;
    logic [31:0] sh_org_y = '0;
    logic [15:0] sh_cos = 16'h4000;
    logic [15:0] sh_sin = 16'h0000;

    // scan state of the predictor
    int unsigned scan_col = 0;
    int unsigned scan_row = 0;
    logic [31:0] row_x = '0;
    logic [31:0] row_y = '0;
    logic [31:0] pt_x = '0;
    logic [31:0] pt_y = '0;
    logic [23:0] held_pixel = '0;

    plot_beat_t plot_q[$];
    int mismatch_cnt = 0;
    int pixels_sent = 0;
    int stuck_cycles = 0;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;

    rotated_pixel_color_stream_top u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [31:0] q14_step(input logic [15:0] v);
        q14_step = {{14{v[15]}}, v, 2'b00};
    endfunction

    function automatic int unsigned clamp_dim(input logic [12:0] d);
        if (d == 13'd0) begin
            clamp_dim = 1;
        end else if (d > 13'd4096) begin
            clamp_dim = 4096;
        end else begin
            clamp_dim = 32'(d);
        end
    endfunction

    // works out the plot beat of one pixel and advances the scan
    function automatic plot_beat_t predict_plot(input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b);
        plot_beat_t  pb;
        int unsigned w;
        int unsigned h;
        int unsigned luma;
        int unsigned sc;
        int unsigned sr;
        logic [23:0] pix;
        logic        differ;
        w = clamp_dim(sh_width);
        h = clamp_dim(sh_height);
        pix = {r, g, b};
        if (scan_col == 0 && scan_row == 0) begin
            held_pixel = '0;
            pt_x = sh_org_x;
            pt_y = sh_org_y;
            row_x = sh_org_x;
            row_y = sh_org_y;
        end
        differ = (pix != held_pixel);
        case (sh_mode)
            MODE_GREY: begin
                luma = (K_RED * r + K_GREEN * g + K_BLUE * b + K_ROUND) >> 16;
                pb.red = luma[7:0];
                pb.green = luma[7:0];
                pb.blue = luma[7:0];
            end
            MODE_GREEN: begin
                pb.red = 8'd255 - g;
                pb.green = 8'd255;
                pb.blue = 8'd255 - g;
            end
            MODE_RED: begin
                pb.red = 8'd255;
                pb.green = 8'd255 - r;
                pb.blue = 8'd255 - r;
                differ = (r != held_pixel[23:16]);
            end
            MODE_BLUE: begin
                pb.red = 8'd255 - b;
                pb.green = 8'd255 - b;
                pb.blue = 8'd255;
                differ = (b != held_pixel[7:0]);
            end
            default: begin
                pb.red = r;
                pb.green = g;
                pb.blue = b;
            end
        endcase
        if (differ) begin
            held_pixel = pix;
        end
        sc = sh_mirror[0] ? (w - 1 - scan_col) : scan_col;
        sr = sh_mirror[1] ? (h - 1 - scan_row) : scan_row;
        pb.pos_x = pt_x;
        pb.pos_y = pt_y;
        pb.color_set = differ;
        pb.src_col = sc[11:0];
        pb.src_row = sr[11:0];
        pb.frame_end = 1'b0;
        pt_x = pt_x + q14_step(sh_cos);
        pt_y = pt_y + q14_step(sh_sin);
        scan_col++;
        if (scan_col >= w) begin
            scan_col = 0;
            row_x = row_x - q14_step(sh_sin);
            row_y = row_y + q14_step(sh_cos);
            pt_x = row_x;
            pt_y = row_y;
            scan_row++;
            if (scan_row >= h) begin
                scan_row = 0;
                pb.frame_end = 1'b1;
            end
        end
        return pb;
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_COLOR_MODE:   sh_mode = val[2:0];
            CFG_MIRROR_FLAGS: sh_mirror = val[1:0];
            CFG_IMAGE_WIDTH:  sh_width = val[12:0];
            CFG_IMAGE_HEIGHT: sh_height = val[12:0];
            CFG_ORIGIN_X:     sh_org_x = val;
            CFG_ORIGIN_Y:     sh_org_y = val;
            CFG_ROT_COS:      sh_cos = val[15:0];
            CFG_ROT_SIN:      sh_sin = val[15:0];
            default: ;
        endcase
    endtask

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {b, g, r};
        do @(posedge aclk); while (!s_tready);
        plot_q.push_back(predict_plot(r, g, b));
        pixels_sent++;
    endtask

    // stop sending and let every predicted beat come out
    task automatic settle_stream();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (plot_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    // result side: random stalls, then each beat against the oldest prediction
    initial begin : plot_checker
        int stall;
        plot_beat_t want;
        @(posedge aclk iff aresetn);
        forever begin
            stall = rx_idle_on ? $urandom_range(0, 14) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (plot_q.size() == 0) begin
                $display("%0t: beat with nothing predicted, expected none, actual %h %b %b",
                         $time, m_tdata, m_tuser, m_tlast);
                mismatch_cnt++;
            end else begin
                want = plot_q.pop_front();
                check_field("pos_x", want.pos_x, m_tdata[31:0]);
                check_field("pos_y", want.pos_y, m_tdata[63:32]);
                check_field("out_red", 32'(want.red), 32'(m_tdata[71:64]));
                check_field("out_green", 32'(want.green), 32'(m_tdata[79:72]));
                check_field("out_blue", 32'(want.blue), 32'(m_tdata[87:80]));
                check_field("src_col", 32'(want.src_col), 32'(m_tdata[99:88]));
                check_field("src_row", 32'(want.src_row), 32'(m_tdata[111:100]));
                check_field("color_set", 32'(want.color_set), 32'(m_tuser));
                check_field("frame_end", 32'(want.frame_end), 32'(m_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en || !aresetn) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STUCK_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [12:0] pick_dim();
        case ($urandom_range(0, 19))
            0: pick_dim = 13'd0;
            1: pick_dim = 13'd4096;
            2: pick_dim = 13'h1FFF;
            3: pick_dim = 13'($urandom);
            4, 5: pick_dim = 13'($urandom_range(9, 64));
            default: pick_dim = 13'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [15:0] pick_trig();
        case ($urandom_range(0, 7))
            0: pick_trig = 16'h4000;
            1: pick_trig = 16'hC000;
            2: pick_trig = 16'h8000;
            3: pick_trig = 16'h7FFF;
            4: pick_trig = 16'($urandom);
            default: pick_trig = 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic logic [31:0] pick_origin();
        case ($urandom_range(0, 7))
            0: pick_origin = 32'h8000_0000;
            1: pick_origin = 32'h7FFF_FFFF;
            2: pick_origin = 32'h0000_0000;
            default: pick_origin = $urandom;
        endcase
    endfunction

    // one-pixel frames at reset settings, black then white
    task automatic test_reset_defaults();
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        settle_stream();
    endtask

    // second pixel differs in green only, so the tints keyed on red or blue stay quiet
    task automatic test_color_modes();
        write_reg(CFG_IMAGE_WIDTH, 32'd8);
        write_reg(CFG_IMAGE_HEIGHT, 32'd1);
        for (int m = 0; m < 8; m++) begin
            write_reg(CFG_COLOR_MODE, 32'(m));
            send_pixel(8'd200, 8'd17, 8'd99);
            send_pixel(8'd200, 8'd240, 8'd99);
            settle_stream();
        end
    endtask

    task automatic test_geometry();
        // oversize width, zero height, both mirrors and extreme origin and angle
        write_reg(CFG_COLOR_MODE, 32'(MODE_PASS));
        write_reg(CFG_MIRROR_FLAGS, 32'd3);
        write_reg(CFG_IMAGE_WIDTH, 32'h1FFF);
        write_reg(CFG_IMAGE_HEIGHT, 32'd0);
        write_reg(CFG_ORIGIN_X, 32'h8000_0000);
        write_reg(CFG_ORIGIN_Y, 32'h7FFF_FFFF);
        write_reg(CFG_ROT_COS, 32'h0000_8000);
        write_reg(CFG_ROT_SIN, 32'h0000_7FFF);
        send_pixel(8'h01, 8'h80, 8'hFE);
        send_pixel(8'h01, 8'h80, 8'hFE);
        send_pixel(8'hFF, 8'h00, 8'h7F);
        settle_stream();
        // row shrunk under the column counter: wraps and mirrors modulo 4096
        write_reg(CFG_IMAGE_WIDTH, 32'd2);
        write_reg(CFG_ROT_COS, 32'h0000_4000);
        write_reg(CFG_ROT_SIN, 32'h0000_C000);
        send_pixel(8'h55, 8'hAA, 8'h55);
        send_pixel(8'hAA, 8'h55, 8'hAA);
        send_pixel(8'h0F, 8'hF0, 8'h3C);
        settle_stream();
    endtask

    task automatic test_random();
        int phase;
        int burst;
        logic [23:0] pix;
        phase = 0;
        pix = '0;
        while (pixels_sent < RANDOM_PIXELS - 25) begin
            case ($urandom_range(0, 4))
                0: begin tx_idle_on = 1'b0; rx_idle_on = 1'b0; end
                1: begin tx_idle_on = 1'b0; rx_idle_on = 1'b1; end
                2: begin tx_idle_on = 1'b1; rx_idle_on = 1'b0; end
                default: begin tx_idle_on = 1'b1; rx_idle_on = 1'b1; end
            endcase
            write_reg(CFG_COLOR_MODE, 32'($urandom_range(0, 7)));
            write_reg(CFG_MIRROR_FLAGS, 32'($urandom_range(0, 3)));
            write_reg(CFG_IMAGE_WIDTH, 32'(pick_dim()));
            write_reg(CFG_IMAGE_HEIGHT, 32'(pick_dim()));
            write_reg(CFG_ORIGIN_X, pick_origin());
            write_reg(CFG_ORIGIN_Y, pick_origin());
            write_reg(CFG_ROT_COS, 32'(pick_trig()));
            write_reg(CFG_ROT_SIN, 32'(pick_trig()));
            burst = $urandom_range(20, 80);
            for (int i = 0; i < burst; i++) begin
                // repeats and single-channel changes keep the colour-set flag low often
                case ($urandom_range(0, 9))
                    0, 1, 2: ;
                    3, 4: pix[8 * $urandom_range(0, 2) +: 8] = 8'($urandom);
                    5: pix = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
                    default: pix = 24'($urandom);
                endcase
                send_pixel(pix[23:16], pix[15:8], pix[7:0]);
                if ((phase == 0 && i == 10) || $urandom_range(0, 99) == 0) begin
                    settle_stream();
                end
            end
            settle_stream();
            phase++;
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_color_modes();
        test_geometry();
        test_random();
        settle_stream();
        repeat (8) @(posedge aclk);
        if (mismatch_cnt == 0 && plot_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
